@@ rtl/mmc_pkg.sv @@
// Shared types, codes and widths for the cartridge bank mapper.
// No dependencies; every other file imports this package.
`default_nettype none

package mmc_pkg;

    // Field widths
    localparam int CMD_W       = 3;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int TGT_W       = 3;
    localparam int MAP_W       = 19;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam int BANK_CNT_W  = 7;
    localparam int PRG_BANK_W  = 6;
    localparam int CHR_BANK_W  = 8;
    localparam int CHR_WINDOWS = 6;
    localparam int PRG_WINDOWS = 2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CPU_WRITE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CPU_READ  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PPU_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PPU_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IRQ_CLOCK = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NT_MAP    = 3'd5;

    // Target memories
    localparam logic [TGT_W-1:0] TGT_NONE = 3'd0;
    localparam logic [TGT_W-1:0] TGT_PRG  = 3'd1;
    localparam logic [TGT_W-1:0] TGT_SRAM = 3'd2;
    localparam logic [TGT_W-1:0] TGT_CHR  = 3'd3;
    localparam logic [TGT_W-1:0] TGT_NT   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_IS_RAM     = 2'd1;

    localparam logic [BANK_CNT_W-1:0] PRG_BANK_COUNT_RESET = 7'd32;

    // Bank register value masks
    localparam logic [DATA_W-1:0] CHR_2K_MASK = 8'b1111_1110;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } mmc_item_t;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [MAP_W-1:0] mapped_address;
        logic             write_enable;
        logic             irq_line;
        logic             ram_enable;
        logic             ram_write_protect;
    } mmc_result_t;

    // Mapper state as seen by the translation logic
    typedef struct packed {
        logic                                 prg_mode;
        logic                                 chr_inversion;
        logic [CHR_WINDOWS-1:0][CHR_BANK_W-1:0] chr_banks;
        logic [PRG_WINDOWS-1:0][PRG_BANK_W-1:0] prg_banks;
        logic                                 mirror_horizontal;
        logic                                 irq_pending_next;
        logic [1:0]                           ram_protect_next;
    } mmc_view_t;

endpackage

`default_nettype wire

@@ rtl/mmc_if.sv @@
// Valid/ready channel interfaces for command beats and result beats.
// Depends on mmc_pkg for field widths.
`default_nettype none

interface mmc_in_if;
    import mmc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output command, output address, output write_data,
                    input ready);
    modport sink   (input valid, input command, input address, input write_data,
                    output ready);
endinterface

interface mmc_out_if;
    import mmc_pkg::*;

    logic             valid;
    logic             ready;
    logic [TGT_W-1:0] target;
    logic [MAP_W-1:0] mapped_address;
    logic             write_enable;
    logic             irq_line;
    logic             ram_enable;
    logic             ram_write_protect;

    modport source (output valid, output target, output mapped_address,
                    output write_enable, output irq_line, output ram_enable,
                    output ram_write_protect, input ready);
    modport sink   (input valid, input target, input mapped_address,
                    input write_enable, input irq_line, input ram_enable,
                    input ram_write_protect, output ready);
endinterface

`default_nettype wire

@@ rtl/mmc_state.sv @@
// Mapper register file and scanline IRQ counter, updated once per beat.
// Depends on mmc_pkg.
`default_nettype none

module mmc_state (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire mmc_pkg::mmc_item_t item,
    output mmc_pkg::mmc_view_t      view
);
    import mmc_pkg::*;

    logic [2:0]                             register_select_reg, register_select_next;
    logic                                   prg_mode_reg, prg_mode_next;
    logic                                   chr_inversion_reg, chr_inversion_next;
    logic [CHR_WINDOWS-1:0][CHR_BANK_W-1:0] chr_banks_reg, chr_banks_next;
    logic [PRG_WINDOWS-1:0][PRG_BANK_W-1:0] prg_banks_reg, prg_banks_next;
    logic                                   mirror_horizontal_reg, mirror_horizontal_next;
    logic [1:0]                             ram_protect_reg, ram_protect_next;
    logic [DATA_W-1:0]                      irq_reload_reg, irq_reload_next;
    logic [DATA_W-1:0]                      irq_count_reg, irq_count_next;
    logic                                   irq_enable_reg, irq_enable_next;
    logic                                   irq_pending_reg, irq_pending_next;

    logic              odd;
    logic [DATA_W-1:0] d;

    assign odd = item.address[0];
    assign d   = item.write_data;

    // Next state for the beat in the input register
    always_comb
    begin
        register_select_next   = register_select_reg;
        prg_mode_next          = prg_mode_reg;
        chr_inversion_next     = chr_inversion_reg;
        chr_banks_next         = chr_banks_reg;
        prg_banks_next         = prg_banks_reg;
        mirror_horizontal_next = mirror_horizontal_reg;
        ram_protect_next       = ram_protect_reg;
        irq_reload_next        = irq_reload_reg;
        irq_count_next         = irq_count_reg;
        irq_enable_next        = irq_enable_reg;
        irq_pending_next       = irq_pending_reg;

        case (item.command)
            CMD_CPU_WRITE:
            begin
                if (item.address[15])
                begin
                    case (item.address[14:13])
                        2'd0:
                        begin
                            if (!odd)
                            begin
                                register_select_next = d[2:0];
                                prg_mode_next        = d[6];
                                chr_inversion_next   = d[7];
                            end
                            else if (register_select_reg < 3'd2)
                                chr_banks_next[register_select_reg] = d & CHR_2K_MASK;
                            else if (register_select_reg < 3'd6)
                                chr_banks_next[register_select_reg] = d;
                            else
                                prg_banks_next[register_select_reg[0]] = d[PRG_BANK_W-1:0];
                        end
                        2'd1:
                        begin
                            if (!odd)
                                mirror_horizontal_next = d[0];
                            else
                                ram_protect_next = d[7:6];
                        end
                        2'd2:
                        begin
                            if (!odd)
                                irq_reload_next = d;
                            else
                                irq_count_next = '0;
                        end
                        default:
                        begin
                            if (!odd)
                            begin
                                irq_enable_next  = 1'b0;
                                irq_pending_next = 1'b0;
                            end
                            else
                                irq_enable_next = 1'b1;
                        end
                    endcase
                end
            end
            CMD_IRQ_CLOCK:
            begin
                // Reload at zero, otherwise count down
                if (irq_count_reg == '0)
                    irq_count_next = irq_reload_reg;
                else
                    irq_count_next = irq_count_reg - 8'd1;
                if (irq_count_next == '0 && irq_enable_reg)
                    irq_pending_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            register_select_reg   <= '0;
            prg_mode_reg          <= 1'b0;
            chr_inversion_reg     <= 1'b0;
            chr_banks_reg         <= '0;
            prg_banks_reg         <= '0;
            mirror_horizontal_reg <= 1'b0;
            ram_protect_reg       <= '0;
            irq_reload_reg        <= '0;
            irq_count_reg         <= '0;
            irq_enable_reg        <= 1'b0;
            irq_pending_reg       <= 1'b0;
        end
        else if (advance)
        begin
            register_select_reg   <= register_select_next;
            prg_mode_reg          <= prg_mode_next;
            chr_inversion_reg     <= chr_inversion_next;
            chr_banks_reg         <= chr_banks_next;
            prg_banks_reg         <= prg_banks_next;
            mirror_horizontal_reg <= mirror_horizontal_next;
            ram_protect_reg       <= ram_protect_next;
            irq_reload_reg        <= irq_reload_next;
            irq_count_reg         <= irq_count_next;
            irq_enable_reg        <= irq_enable_next;
            irq_pending_reg       <= irq_pending_next;
        end
    end

    // Current mapping state plus the status bits reported after this beat
    always_comb
    begin
        view.prg_mode          = prg_mode_reg;
        view.chr_inversion     = chr_inversion_reg;
        view.chr_banks         = chr_banks_reg;
        view.prg_banks         = prg_banks_reg;
        view.mirror_horizontal = mirror_horizontal_reg;
        view.irq_pending_next  = irq_pending_next;
        view.ram_protect_next  = ram_protect_next;
    end

endmodule

`default_nettype wire

@@ rtl/mmc_xlate.sv @@
// Address translation: PRG, CHR, save RAM and nametable decode for one beat.
// Depends on mmc_pkg.
`default_nettype none

module mmc_xlate (
    input  wire logic                               item_valid,
    input  wire mmc_pkg::mmc_item_t                 item,
    input  wire mmc_pkg::mmc_view_t                 view,
    input  wire logic [mmc_pkg::BANK_CNT_W-1:0]     prg_bank_count,
    input  wire logic                               chr_is_ram,
    output mmc_pkg::mmc_result_t                    result,
    output logic                                    has_result
);
    import mmc_pkg::*;

    logic [ADDR_W-1:0]     a;
    logic [1:0]            slot;
    logic [1:0]            slot_eff;
    logic [PRG_BANK_W-1:0] fixed_last;
    logic [PRG_BANK_W-1:0] fixed_second;
    logic [PRG_BANK_W-1:0] prg_page;
    logic [MAP_W-1:0]      prg_offset;
    logic [2:0]            chr_window;
    logic [2:0]            chr_index;
    logic [CHR_BANK_W-1:0] chr_page;
    logic [MAP_W-1:0]      chr_offset;
    logic [MAP_W-1:0]      sram_offset;
    logic [MAP_W-1:0]      nt_offset;

    assign a = item.address;

    // PRG: last bank fixed, second-last swaps with the first window in mode 1
    assign fixed_last   = prg_bank_count[PRG_BANK_W-1:0] - 6'd1;
    assign fixed_second = prg_bank_count[PRG_BANK_W-1:0] - 6'd2;
    assign slot         = a[14:13];
    assign slot_eff     = slot ^ {view.prg_mode, 1'b0};

    always_comb
    begin
        case (slot)
            2'd1:    prg_page = view.prg_banks[1];
            2'd3:    prg_page = fixed_last;
            default: prg_page = (slot_eff == 2'd0) ? view.prg_banks[0] : fixed_second;
        endcase
    end

    assign prg_offset = {prg_page, a[12:0]};

    // CHR: two 2 KB windows and four 1 KB windows, A12 inverted on request
    assign chr_window = a[12:10] ^ {view.chr_inversion, 2'b00};
    assign chr_index  = chr_window[2] ? (chr_window - 3'd2) : {2'b00, chr_window[1]};
    assign chr_page   = view.chr_banks[chr_index];
    assign chr_offset = chr_window[2] ? {1'b0, chr_page, a[9:0]}
                                      : {1'b0, chr_page[7:1], a[10:0]};

    assign sram_offset = {6'd0, a[12:0]};

    // Horizontal mirroring puts A11 on offset bit 10
    assign nt_offset = view.mirror_horizontal ? {8'd0, a[11], a[9:0]}
                                              : {8'd0, a[10:0]};

    // Result selection
    always_comb
    begin
        result     = '0;
        has_result = item_valid;
        case (item.command)
            CMD_CPU_WRITE:
            begin
                if (!a[15] && a[14:13] == 2'b11)
                begin
                    result.target         = TGT_SRAM;
                    result.mapped_address = sram_offset;
                    result.write_enable   = 1'b1;
                end
            end
            CMD_CPU_READ:
            begin
                if (a[15])
                begin
                    result.target         = TGT_PRG;
                    result.mapped_address = prg_offset;
                end
                else if (a[14:13] == 2'b11)
                begin
                    result.target         = TGT_SRAM;
                    result.mapped_address = sram_offset;
                end
            end
            CMD_PPU_READ:
            begin
                if (a[15:13] == 3'd0)
                begin
                    result.target         = TGT_CHR;
                    result.mapped_address = chr_offset;
                end
            end
            CMD_PPU_WRITE:
            begin
                if (a[15:13] == 3'd0 && chr_is_ram)
                begin
                    result.target         = TGT_CHR;
                    result.mapped_address = chr_offset;
                    result.write_enable   = 1'b1;
                end
            end
            CMD_IRQ_CLOCK:
            begin
            end
            CMD_NT_MAP:
            begin
                result.target         = TGT_NT;
                result.mapped_address = nt_offset;
            end
            default: has_result = 1'b0;
        endcase
        result.irq_line          = view.irq_pending_next;
        result.ram_enable        = view.ram_protect_next[1];
        result.ram_write_protect = view.ram_protect_next[0];
    end

endmodule

`default_nettype wire

@@ rtl/cartridge_bank_mapper_with_scanline_irq_top.sv @@
// Top level of the cartridge bank mapper: input register, state, translation
// and result register. Depends on mmc_pkg, mmc_if, mmc_state and mmc_xlate.
//
// Usage:
//   in_ch carries one command beat (command, address, write_data) per cycle;
//   out_ch returns one result beat (target, mapped_address, write_enable,
//   irq_line, ram_enable, ram_write_protect) for each command 0 to 5.
//   Commands 6 and 7 are consumed and give no result.
//   A beat accepted from in_ch waits in the input register until the result
//   register is free, and its result is then loaded there, raising
//   out_ch.valid for commands 0 to 5. Throughput is one beat per cycle while
//   out_ch.ready stays high, set by the single translation stage between the two registers.
//   Configuration (cfg_write_enable, cfg_index, cfg_data) writes one register
//   per enabled edge, the bank count or the CHR RAM flag; write only while idle.
//   Reset clears the mapper registers, the IRQ counter and both pipeline
//   valid bits; the bank count returns to 32 and CHR is treated as ROM.
//   When out_ch.ready is low the result holds; the input register keeps
//   one further beat, and in_ch.ready drops until the result is taken.
`default_nettype none

module cartridge_bank_mapper_with_scanline_irq_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write_enable,
    input  wire logic [mmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [mmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    mmc_in_if.sink                                  in_ch,
    mmc_out_if.source                               out_ch
);
    import mmc_pkg::*;

    logic [BANK_CNT_W-1:0] prg_bank_count_reg;
    logic                  chr_is_ram_reg;

    logic        in_valid_reg, in_valid_next;
    mmc_item_t   in_item_reg;
    logic        out_valid_reg, out_valid_next;
    mmc_result_t out_result_reg;

    logic        advance;
    logic        accept;
    mmc_view_t   view;
    mmc_result_t result;
    logic        has_result;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg <= PRG_BANK_COUNT_RESET;
            chr_is_ram_reg     <= 1'b0;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_PRG_BANK_COUNT: prg_bank_count_reg <= cfg_data[BANK_CNT_W-1:0];
                CFG_CHR_IS_RAM:     chr_is_ram_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Handshake: input register moves on when the result register is free
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = has_result;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.command    <= in_ch.command;
            in_item_reg.address    <= in_ch.address;
            in_item_reg.write_data <= in_ch.write_data;
        end
        if (advance)
            out_result_reg <= result;
    end

    mmc_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .view    (view)
    );

    mmc_xlate u_xlate (
        .item_valid     (in_valid_reg),
        .item           (in_item_reg),
        .view           (view),
        .prg_bank_count (prg_bank_count_reg),
        .chr_is_ram     (chr_is_ram_reg),
        .result         (result),
        .has_result     (has_result)
    );

    // Result channel
    assign out_ch.valid             = out_valid_reg;
    assign out_ch.target            = out_result_reg.target;
    assign out_ch.mapped_address    = out_result_reg.mapped_address;
    assign out_ch.write_enable      = out_result_reg.write_enable;
    assign out_ch.irq_line          = out_result_reg.irq_line;
    assign out_ch.ram_enable        = out_result_reg.ram_enable;
    assign out_ch.ram_write_protect = out_result_reg.ram_write_protect;

endmodule

`default_nettype wire
